@@ hw/rtl/yrc_pkg.sv @@
// Shared types and constants of the YUV to RGB crop converter.
// Used by every module under hw/rtl; depends on nothing else.
package yrc_pkg;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int CFG_IDX_W = 3;
    localparam int SUM_W     = 21;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [POS_W-1:0] RST_CROP_LEFT    = 12'd0;
    localparam logic [POS_W-1:0] RST_CROP_TOP     = 12'd0;
    localparam logic [DIM_W-1:0] RST_CROP_WIDTH   = 13'd640;
    localparam logic [DIM_W-1:0] RST_CROP_HEIGHT  = 13'd480;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [8:0] CHROMA_CENTER = 9'd128;

    localparam logic signed [SUM_W-1:0] K_Y  = 21'sd1164;
    localparam logic signed [SUM_W-1:0] K_RV = 21'sd1596;
    localparam logic signed [SUM_W-1:0] K_GU = 21'sd391;
    localparam logic signed [SUM_W-1:0] K_GV = 21'sd813;
    localparam logic signed [SUM_W-1:0] K_BU = 21'sd2018;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 21'sd262143;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CROP_LEFT    = 3'd2,
        REG_CROP_TOP     = 3'd3,
        REG_CROP_WIDTH   = 3'd4,
        REG_CROP_HEIGHT  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]       luma;
        logic [7:0]       chroma_red;
        logic [7:0]       chroma_blue;
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] line;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       window_end;
    } out_item_t;

    typedef struct packed {
        logic [POS_W-1:0] x_lo;
        logic [DIM_W-1:0] x_end;
        logic [POS_W-1:0] x_last;
        logic [POS_W-1:0] y_lo;
        logic [DIM_W-1:0] y_end;
        logic [POS_W-1:0] y_last;
    } win_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [7:0] clamp_component(input logic signed [SUM_W-1:0] s);
        logic [7:0] c;
        if (s < 0) begin
            c = 8'd0;
        end else if (s > SUM_MAX) begin
            c = 8'hff;
        end else begin
            c = s[17:10];
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/yuv_to_rgb_crop_converter.sv @@
// Top level of the YUV to RGB crop converter: handshakes and stage valid bits.
// Depends on yrc_pkg, yrc_config and yrc_datapath.
//
// One input item is a pixel: its Y byte, the V and U bytes of its 2x2 chroma
// block, and its column and line. A pixel inside the crop window, clipped to
// the frame edge, gives one output item with R, G, B and a flag that marks
// the window's bottom-right pixel; a pixel outside the window gives nothing.
// Both channels use valid and ready. The block takes one item per cycle while
// in_ready is high and has four register stages; out_valid rises once an
// accepted item has passed all four. Each stage loads whenever it is empty or
// the stage after it moves, so a stalled receiver fills the empty stages first
// and in_ready drops only when all four hold an item. Configuration is to be
// written through cfg_en, cfg_index and cfg_data only while the block is idle,
// which the block does not enforce; writes to unused indexes are ignored.
// Reset is asynchronous and active low: it empties the pipeline and restores
// a 640 by 480 frame with a full-frame window.
module yuv_to_rgb_crop_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  yrc_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output yrc_pkg::out_item_t            out_item,
    input  logic                          cfg_en,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrc_pkg::DIM_W-1:0]     cfg_data
);
    import yrc_pkg::*;

    win_t     win;
    pipe_en_t en;
    logic     s2_inside;
    logic     v1_reg;
    logic     v2_reg;
    logic     v3_reg;
    logic     v4_reg;

    always_comb begin
        en.s4 = !v4_reg || out_ready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= in_valid;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg && s2_inside;
            end
            if (en.s4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    yrc_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .win       (win)
    );

    yrc_datapath u_datapath (
        .clk       (clk),
        .en        (en),
        .in_item   (in_item),
        .win       (win),
        .s2_inside (s2_inside),
        .out_item  (out_item)
    );

    assign in_ready  = en.s1;
    assign out_valid = v4_reg;

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input blocked while a stage is empty");

    a_window_drop: assert property (@(posedge clk) disable iff (!rst_n)
        en.s3 |=> (v3_reg == $past(v2_reg && s2_inside)))
        else $error("stage three valid does not follow the window test");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && out_ready && !v3_reg) |=> !v4_reg)
        else $error("taken item repeated at the output");

    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (!v2_reg && v1_reg) |=> v2_reg)
        else $error("stage one item did not move into an empty stage two");
`endif

endmodule

@@ hw/rtl/yrc_config.sv @@
// Configuration registers and the registered bounds of the clipped crop window.
// Depends on yrc_pkg.
module yrc_config (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_en,
    input  logic [yrc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yrc_pkg::DIM_W-1:0]     cfg_data,
    output yrc_pkg::win_t                win
);
    import yrc_pkg::*;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [POS_W-1:0] crop_left_reg;
    logic [POS_W-1:0] crop_top_reg;
    logic [DIM_W-1:0] crop_width_reg;
    logic [DIM_W-1:0] crop_height_reg;
    logic [DIM_W:0]   x_sum;
    logic [DIM_W:0]   y_sum;
    logic [DIM_W-1:0] x_end;
    logic [DIM_W-1:0] y_end;
    logic [DIM_W-1:0] x_last_full;
    logic [DIM_W-1:0] y_last_full;
    win_t             win_next;
    win_t             win_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            crop_left_reg    <= RST_CROP_LEFT;
            crop_top_reg     <= RST_CROP_TOP;
            crop_width_reg   <= RST_CROP_WIDTH;
            crop_height_reg  <= RST_CROP_HEIGHT;
        end else if (cfg_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_CROP_LEFT:    crop_left_reg    <= cfg_data[POS_W-1:0];
                REG_CROP_TOP:     crop_top_reg     <= cfg_data[POS_W-1:0];
                REG_CROP_WIDTH:   crop_width_reg   <= cfg_data;
                REG_CROP_HEIGHT:  crop_height_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The window end is the smaller of start plus width and the frame edge.
    always_comb begin
        x_sum = {2'b00, crop_left_reg} + {1'b0, sat_dim(crop_width_reg)};
        y_sum = {2'b00, crop_top_reg} + {1'b0, sat_dim(crop_height_reg)};
        x_end = (x_sum > {1'b0, sat_dim(frame_width_reg)}) ?
                sat_dim(frame_width_reg) : x_sum[DIM_W-1:0];
        y_end = (y_sum > {1'b0, sat_dim(frame_height_reg)}) ?
                sat_dim(frame_height_reg) : y_sum[DIM_W-1:0];
        x_last_full = x_end - DIM_W'(1);
        y_last_full = y_end - DIM_W'(1);
        win_next.x_lo   = crop_left_reg;
        win_next.x_end  = x_end;
        win_next.x_last = x_last_full[POS_W-1:0];
        win_next.y_lo   = crop_top_reg;
        win_next.y_end  = y_end;
        win_next.y_last = y_last_full[POS_W-1:0];
    end

    always_ff @(posedge clk) begin
        win_reg <= win_next;
    end

    assign win = win_reg;

endmodule

@@ hw/rtl/yrc_datapath.sv @@
// Four-stage pixel datapath: offset removal, window test and products, sums, clamp.
// Depends on yrc_pkg; stage enables come from the top level.
module yrc_datapath (
    input  logic               clk,
    input  yrc_pkg::pipe_en_t  en,
    input  yrc_pkg::in_item_t  in_item,
    input  yrc_pkg::win_t      win,
    output logic               s2_inside,
    output yrc_pkg::out_item_t out_item
);
    import yrc_pkg::*;

    logic [7:0]              y_reg;
    logic signed [8:0]       v_reg;
    logic signed [8:0]       u_reg;
    logic [POS_W-1:0]        col_reg;
    logic [POS_W-1:0]        row_reg;
    logic [7:0]              y_next;
    logic signed [8:0]       v_next;
    logic signed [8:0]       u_next;

    logic signed [SUM_W-1:0] yw_reg;
    logic signed [SUM_W-1:0] rv_reg;
    logic signed [SUM_W-1:0] gu_reg;
    logic signed [SUM_W-1:0] gv_reg;
    logic signed [SUM_W-1:0] bu_reg;
    logic                    inside_reg;
    logic                    last2_reg;
    logic                    inside_next;
    logic                    last2_next;

    logic signed [SUM_W-1:0] r_reg;
    logic signed [SUM_W-1:0] g_reg;
    logic signed [SUM_W-1:0] b_reg;
    logic                    last3_reg;

    out_item_t               out_reg;
    out_item_t               out_next;

    always_comb begin
        y_next = (in_item.luma > LUMA_OFFSET) ? (in_item.luma - LUMA_OFFSET) : 8'd0;
        v_next = $signed({1'b0, in_item.chroma_red} - CHROMA_CENTER);
        u_next = $signed({1'b0, in_item.chroma_blue} - CHROMA_CENTER);
    end

    always_ff @(posedge clk) begin
        if (en.s1) begin
            y_reg   <= y_next;
            v_reg   <= v_next;
            u_reg   <= u_next;
            col_reg <= in_item.column;
            row_reg <= in_item.line;
        end
    end

    always_comb begin
        inside_next = (col_reg >= win.x_lo) && ({1'b0, col_reg} < win.x_end) &&
                      (row_reg >= win.y_lo) && ({1'b0, row_reg} < win.y_end);
        last2_next  = (col_reg == win.x_last) && (row_reg == win.y_last);
    end

    always_ff @(posedge clk) begin
        if (en.s2) begin
            yw_reg     <= $signed({{(SUM_W-8){1'b0}}, y_reg}) * K_Y;
            rv_reg     <= SUM_W'(v_reg) * K_RV;
            gu_reg     <= SUM_W'(u_reg) * K_GU;
            gv_reg     <= SUM_W'(v_reg) * K_GV;
            bu_reg     <= SUM_W'(u_reg) * K_BU;
            inside_reg <= inside_next;
            last2_reg  <= last2_next;
        end
    end

    assign s2_inside = inside_reg;

    always_ff @(posedge clk) begin
        if (en.s3) begin
            r_reg     <= yw_reg + rv_reg;
            g_reg     <= yw_reg - gu_reg - gv_reg;
            b_reg     <= yw_reg + bu_reg;
            last3_reg <= last2_reg;
        end
    end

    always_comb begin
        out_next.red        = clamp_component(r_reg);
        out_next.green      = clamp_component(g_reg);
        out_next.blue       = clamp_component(b_reg);
        out_next.window_end = last3_reg;
    end

    always_ff @(posedge clk) begin
        if (en.s4) begin
            out_reg <= out_next;
        end
    end

    assign out_item = out_reg;

endmodule
